>>> rtl/abs_pkg.sv
`default_nettype none

package abs_pkg;

  // fixed field widths
  localparam int IDX_W      = 17;
  localparam int LR_W       = 16;
  localparam int ITHR_W     = 16;
  localparam int LVL_W      = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  // register reset values
  localparam logic [LR_W-1:0]   LR_RESET   = 16'd62259;
  localparam logic [ITHR_W-1:0] ITHR_RESET = 16'd655;
  localparam logic [LVL_W-1:0]  LVL_RESET  = 17'd62960;

  // rounding half of the q0.16 blend weight
  localparam int LR_HALF = 1 << (LR_W - 1);

  // foreground = (100*cur - 62*bg + 19) / 38, threshold gain 5
  localparam int FG_CUR_GAIN = 100;
  localparam int FG_BG_GAIN  = 62;
  localparam int FG_ROUND    = 19;
  localparam int FG_DIV      = 38;
  localparam int THR_GAIN    = 5;

  typedef logic [IDX_W-1:0] pix_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE = 2'd0,
    CFG_INIT_THR   = 2'd1,
    CFG_FG_LEVEL   = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/abs_stream_if.sv
`default_nettype none

interface abs_in_if #(
  parameter int SAMPLE_BITS = 16
);
  import abs_pkg::*;

  logic                   valid;
  logic                   ready;
  pix_idx_t               pixel_index;
  logic [SAMPLE_BITS-1:0] current_pixel;
  logic [SAMPLE_BITS-1:0] previous_pixel;
  logic [SAMPLE_BITS-1:0] older_pixel;
  logic                   init_pixel;

  modport source (
    output valid, pixel_index, current_pixel, previous_pixel, older_pixel, init_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_index, current_pixel, previous_pixel, older_pixel, init_pixel,
    output ready
  );
endinterface

interface abs_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS+2:0] foreground_value;
  logic                        foreground_bit;
  logic                        model_updated;

  modport source (
    output valid, foreground_value, foreground_bit, model_updated,
    input  ready
  );
  modport sink (
    input  valid, foreground_value, foreground_bit, model_updated,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/abs_cdiv.sv
`default_nettype none

// unsigned divide by a constant: reciprocal multiply, product registered
module abs_cdiv #(
  parameter int NUM_W   = 17,
  parameter int DIVISOR = 38
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  output logic      [NUM_W-1:0] quot
);
  localparam int LOG_D  = $clog2(DIVISOR);
  localparam int SHIFT  = NUM_W + LOG_D;
  localparam int RCP_W  = NUM_W + 1;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam logic [63:0] RCP64 =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP64);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(num) * PROD_W'(RCP);
    end
  end

  // rounded-up reciprocal is exact for every num below 2**NUM_W
  assign quot = NUM_W'(prod_r >> SHIFT);

endmodule

`default_nettype wire

>>> rtl/adaptive_background_subtract.sv
`default_nettype none

// channel   dir  handshake       payload
// in_ch     in   valid/ready     pixel_index, current/previous/older_pixel, init_pixel
// out_ch    out  valid/ready     foreground_value, foreground_bit, model_updated
// cfg_*     in   cfg_we only     cfg_index, cfg_data (learn rate, init threshold, level)
//
// one pixel per clock unless a hazard or a stalled output holds the input
// the background/threshold memories are read-modify-written: read as an item leaves stage c,
// written back as it leaves stage g; a pixel whose address is still being updated by one of
// the 4 items ahead waits; raster-order streams never wait
// reset clears control and registers only; the memories hold garbage until written
// a stalled output holds the pipeline only when the last stage is occupied

module adaptive_background_subtract #(
  parameter int PIXEL_COUNT = 131072,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  abs_in_if.sink                                  in_ch,
  abs_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [abs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [abs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import abs_pkg::*;

  localparam int F     = SAMPLE_BITS;
  localparam int THR_W = F + 3;                       // threshold q3.f
  localparam int FG_W  = F + 3;                       // foreground signed q2.f
  localparam int AW    = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int QN_W  = IDX_W + AW + 1;
  localparam int UW    = F + 8;                       // biased foreground numerator
  localparam int P1_W  = F + LR_W + 2;                // background blend product
  localparam int P2_W  = THR_W + LR_W + 2;            // threshold blend product
  localparam int CMP_W = (FG_W > LVL_W + 1) ? FG_W : LVL_W + 1;

  // numerator bias keeps the floor division unsigned: + 38 * 2**(f+1)
  localparam logic [63:0] FG_BIAS64 = 64'(FG_ROUND) + (64'(FG_DIV) << (F + 1));
  localparam logic [UW-1:0] FG_BIAS   = UW'(FG_BIAS64);
  localparam logic [UW-1:0] FG_OFFSET = UW'(64'd1 << (F + 1));

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [LR_W-1:0]   learn_rate_r;
  logic [ITHR_W-1:0] init_thr_r;
  logic [LVL_W-1:0]  fg_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= LR_RESET;
      init_thr_r   <= ITHR_RESET;
      fg_level_r   <= LVL_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LEARN_RATE: learn_rate_r <= cfg_data[LR_W-1:0];
        CFG_INIT_THR:   init_thr_r   <= cfg_data[ITHR_W-1:0];
        CFG_FG_LEVEL:   fg_level_r   <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control
  // a: input  b: address reciprocal  c: address / memory read
  // d: compare + bg blend multiply  e: bg blend add  f: threshold multiply
  // g: threshold add + write back + fg reciprocal  h: fg result
  // ---------------------------------------------------------------------------
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r, h_v_r, out_v_r;
  logic adv;   // back half moves
  logic haz;   // read stage address still pending a write
  logic fe;    // front half moves

  logic [AW-1:0] c_addr_r, d_addr_r, e_addr_r, f_addr_r, g_addr_r;
  logic          e_wr_r, f_wr_r, g_wr_r;

  assign adv = !(h_v_r && out_v_r && !out_ch.ready);
  assign haz = c_v_r && ((d_v_r && d_addr_r == c_addr_r) ||
                         (e_v_r && e_wr_r && e_addr_r == c_addr_r) ||
                         (f_v_r && f_wr_r && f_addr_r == c_addr_r) ||
                         (g_v_r && g_wr_r && g_addr_r == c_addr_r));
  assign fe  = adv && !haz;

  assign in_ch.ready = fe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      e_v_r   <= 1'b0;
      f_v_r   <= 1'b0;
      g_v_r   <= 1'b0;
      h_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (fe) begin
        a_v_r <= in_ch.valid;
        b_v_r <= a_v_r;
        c_v_r <= b_v_r;
      end
      if (adv) begin
        d_v_r <= c_v_r && !haz;   // bubble while the read waits
        e_v_r <= d_v_r;
        f_v_r <= e_v_r;
        g_v_r <= f_v_r;
        h_v_r <= g_v_r;
      end
      if (!out_v_r || out_ch.ready) begin
        out_v_r <= h_v_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: input transfer
  // ---------------------------------------------------------------------------
  pix_idx_t      a_idx_r;
  logic [F-1:0]  a_cur_r, a_prev_r, a_old_r;
  logic          a_init_r;

  always_ff @(posedge clk) begin
    if (fe) begin
      a_idx_r  <= in_ch.pixel_index;
      a_cur_r  <= in_ch.current_pixel;
      a_prev_r <= in_ch.previous_pixel;
      a_old_r  <= in_ch.older_pixel;
      a_init_r <= in_ch.init_pixel;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: pixel_index / PIXEL_COUNT by reciprocal
  // ---------------------------------------------------------------------------
  pix_idx_t      b_idx_r;
  pix_idx_t      b_quot;
  logic [F-1:0]  b_cur_r, b_prev_r, b_old_r;
  logic          b_init_r;

  abs_cdiv #(
    .NUM_W   (IDX_W),
    .DIVISOR (PIXEL_COUNT)
  ) u_addr_div (
    .clk  (clk),
    .en   (fe),
    .num  (a_idx_r),
    .quot (b_quot)
  );

  always_ff @(posedge clk) begin
    if (fe) begin
      b_idx_r  <= a_idx_r;
      b_cur_r  <= a_cur_r;
      b_prev_r <= a_prev_r;
      b_old_r  <= a_old_r;
      b_init_r <= a_init_r;
    end
  end

  // remainder gives the wrapped memory address
  logic [QN_W-1:0] b_qn;
  logic [QN_W-1:0] b_rem;
  logic [AW-1:0]   c_addr_nxt;

  assign b_qn       = QN_W'(b_quot) * QN_W'(PIXEL_COUNT);
  assign b_rem      = QN_W'(b_idx_r) - b_qn;
  assign c_addr_nxt = b_rem[AW-1:0];

  // ---------------------------------------------------------------------------
  // stage c: address ready, memory read issued on the way to d
  // ---------------------------------------------------------------------------
  logic [F-1:0] c_cur_r, c_prev_r, c_old_r;
  logic         c_init_r;

  always_ff @(posedge clk) begin
    if (fe) begin
      c_addr_r <= c_addr_nxt;
      c_cur_r  <= b_cur_r;
      c_prev_r <= b_prev_r;
      c_old_r  <= b_old_r;
      c_init_r <= b_init_r;
    end
  end

  // background and threshold memories
  logic [F-1:0]     bg_mem  [0:PIXEL_COUNT-1];
  logic [THR_W-1:0] thr_mem [0:PIXEL_COUNT-1];
  logic [F-1:0]     rd_bg_r;
  logic [THR_W-1:0] rd_thr_r;
  logic [F-1:0]     g_bg_r;
  logic [THR_W-1:0] g_thr_nxt;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_bg_r  <= bg_mem[c_addr_r];
      rd_thr_r <= thr_mem[c_addr_r];
    end
    if (adv && g_v_r && g_wr_r) begin
      bg_mem[g_addr_r]  <= g_bg_r;
      thr_mem[g_addr_r] <= g_thr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage d: frame differences against threshold, background blend product
  // ---------------------------------------------------------------------------
  logic [F-1:0] d_cur_r, d_prev_r, d_old_r;
  logic         d_init_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_addr_r <= c_addr_r;
      d_cur_r  <= c_cur_r;
      d_prev_r <= c_prev_r;
      d_old_r  <= c_old_r;
      d_init_r <= c_init_r;
    end
  end

  logic [F-1:0]           d_diff_cp, d_diff_co;
  logic                   d_upd;
  logic signed [LR_W:0]   lr_s;
  logic signed [F:0]      d_bg_delta;
  logic signed [P1_W-1:0] d_bg_prod;
  logic [F-1:0]           d_bg_sel;
  logic [THR_W-1:0]       d_thr_sel;

  assign d_diff_cp = (d_cur_r > d_prev_r) ? d_cur_r - d_prev_r : d_prev_r - d_cur_r;
  assign d_diff_co = (d_cur_r > d_old_r)  ? d_cur_r - d_old_r  : d_old_r - d_cur_r;
  assign d_upd     = !d_init_r && (THR_W'(d_diff_cp) > rd_thr_r) &&
                     (THR_W'(d_diff_co) > rd_thr_r);

  // a*bg + (1-a)*prev == prev + a*(bg - prev), one multiplier
  assign lr_s       = $signed({1'b0, learn_rate_r});
  assign d_bg_delta = $signed({1'b0, rd_bg_r}) - $signed({1'b0, d_prev_r});
  assign d_bg_prod  = P1_W'(lr_s) * P1_W'(d_bg_delta);

  // init loads the current sample and the configured threshold
  assign d_bg_sel  = d_init_r ? d_cur_r : rd_bg_r;
  assign d_thr_sel = d_init_r ? THR_W'(init_thr_r) : rd_thr_r;

  // ---------------------------------------------------------------------------
  // stage e: finish background blend
  // ---------------------------------------------------------------------------
  logic [F-1:0]           e_cur_r, e_prev_r, e_bg_r;
  logic [THR_W-1:0]       e_thr_r;
  logic                   e_upd_r, e_init_r;
  logic signed [P1_W-1:0] e_bg_prod_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_addr_r    <= d_addr_r;
      e_cur_r     <= d_cur_r;
      e_prev_r    <= d_prev_r;
      e_bg_r      <= d_bg_sel;
      e_thr_r     <= d_thr_sel;
      e_upd_r     <= d_upd;
      e_init_r    <= d_init_r;
      e_wr_r      <= d_upd || d_init_r;
      e_bg_prod_r <= d_bg_prod;
    end
  end

  logic signed [P1_W-1:0] e_blend;
  logic [F-1:0]           e_bg_nxt;

  assign e_blend  = e_bg_prod_r + $signed(P1_W'({e_prev_r, LR_W'(0)})) +
                    $signed(P1_W'(LR_HALF));
  assign e_bg_nxt = e_upd_r ? e_blend[LR_W +: F] : e_bg_r;

  // ---------------------------------------------------------------------------
  // stage f: threshold blend product, foreground numerator
  // ---------------------------------------------------------------------------
  logic [F-1:0]     f_cur_r, f_prev_r, f_bg_r;
  logic [THR_W-1:0] f_thr_r;
  logic             f_upd_r, f_init_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_addr_r <= e_addr_r;
      f_cur_r  <= e_cur_r;
      f_prev_r <= e_prev_r;
      f_bg_r   <= e_bg_nxt;
      f_thr_r  <= e_thr_r;
      f_upd_r  <= e_upd_r;
      f_init_r <= e_init_r;
      f_wr_r   <= e_wr_r;
    end
  end

  logic [F-1:0]           f_pd;
  logic [THR_W-1:0]       f_dt;
  logic signed [THR_W:0]  f_thr_delta;
  logic signed [P2_W-1:0] f_thr_prod;
  logic [UW-1:0]          f_fg_num;

  assign f_pd        = (f_prev_r > f_bg_r) ? f_prev_r - f_bg_r : f_bg_r - f_prev_r;
  assign f_dt        = THR_W'(f_pd) * THR_W'(THR_GAIN);
  assign f_thr_delta = $signed({1'b0, f_thr_r}) - $signed({1'b0, f_dt});
  assign f_thr_prod  = P2_W'(lr_s) * P2_W'(f_thr_delta);

  // biased so the value is never negative
  assign f_fg_num = UW'(f_cur_r) * UW'(FG_CUR_GAIN) + FG_BIAS -
                    UW'(f_bg_r) * UW'(FG_BG_GAIN);

  // ---------------------------------------------------------------------------
  // stage g: finish threshold blend, write back, foreground reciprocal
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]       g_dt_r, g_thr_r;
  logic signed [P2_W-1:0] g_thr_prod_r;
  logic                   g_upd_r, g_init_r;
  logic [UW-1:0]          g_fg_num_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g_addr_r     <= f_addr_r;
      g_bg_r       <= f_bg_r;
      g_dt_r       <= f_dt;
      g_thr_r      <= f_thr_r;
      g_thr_prod_r <= f_thr_prod;
      g_upd_r      <= f_upd_r;
      g_init_r     <= f_init_r;
      g_wr_r       <= f_wr_r;
      g_fg_num_r   <= f_fg_num;
    end
  end

  logic signed [P2_W-1:0] g_tsum;

  // blend of two q3.f values never leaves q3.f
  assign g_tsum    = g_thr_prod_r + $signed(P2_W'({g_dt_r, LR_W'(0)})) +
                     $signed(P2_W'(LR_HALF));
  assign g_thr_nxt = g_upd_r ? g_tsum[LR_W +: THR_W] : g_thr_r;

  logic [UW-1:0] h_quot;

  abs_cdiv #(
    .NUM_W   (UW),
    .DIVISOR (FG_DIV)
  ) u_fg_div (
    .clk  (clk),
    .en   (adv),
    .num  (g_fg_num_r),
    .quot (h_quot)
  );

  // ---------------------------------------------------------------------------
  // stage h: remove bias, compare with level
  // ---------------------------------------------------------------------------
  logic h_upd_r, h_init_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_upd_r  <= g_upd_r;
      h_init_r <= g_init_r;
    end
  end

  logic signed [FG_W-1:0]  h_fg;
  logic signed [CMP_W-1:0] h_fg_ext, h_lvl_ext;
  logic                    h_bit;

  // result spans about -1.6 .. 2.6, inside q2.f without clamping
  assign h_fg      = $signed(FG_W'(h_quot - FG_OFFSET));
  assign h_fg_ext  = CMP_W'(h_fg);
  assign h_lvl_ext = $signed(CMP_W'(fg_level_r));
  assign h_bit     = h_fg_ext > h_lvl_ext;

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic signed [FG_W-1:0] out_fg_r;
  logic                   out_bit_r, out_upd_r;

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_fg_r  <= h_init_r ? '0 : h_fg;
      out_bit_r <= !h_init_r && h_bit;
      out_upd_r <= h_upd_r;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.foreground_value = out_fg_r;
  assign out_ch.foreground_bit   = out_bit_r;
  assign out_ch.model_updated    = out_upd_r;

endmodule

`default_nettype wire

>>> sim/bg_model_checker.sv
module bg_model_checker
  import abs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  abs_in_if                     in_mon,
  abs_out_if                    out_mon,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    expected_left,
  output int                    results_checked,
  output int                    updates_seen,
  output int                    marked_seen
);

  localparam longint ONE_Q16 = 65536;
  localparam longint THR_MAX = (longint'(1) << 19) - 1;
  localparam longint FG_MAX  = (longint'(1) << 18) - 1;
  localparam longint FG_MIN  = -(longint'(1) << 18);

  typedef struct {
    longint fg_value;
    logic   fg_bit;
    logic   updated;
  } fg_result_t;

  fg_result_t fg_expected[$];

  // per-pixel model, only entries that were loaded by an init exist
  logic [15:0] bg_model  [pix_idx_t];
  logic [18:0] thr_model [pix_idx_t];

  logic [LR_W-1:0]   learn_q;
  logic [ITHR_W-1:0] ithr_q;
  logic [LVL_W-1:0]  level_q;

  function automatic longint gap(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic fg_result_t predict_foreground(input pix_idx_t idx,
      input logic [15:0] cur_s, input logic [15:0] prev_s,
      input logic [15:0] older_s, input logic init);
    fg_result_t r;
    longint cur, prev, older, bg, thr, nt, a, num, q;
    r.fg_value = 0;
    r.fg_bit   = 1'b0;
    r.updated  = 1'b0;
    cur   = cur_s;
    prev  = prev_s;
    older = older_s;
    a     = learn_q;
    if (init) begin
      bg_model[idx]  = cur_s;
      thr_model[idx] = 19'(ithr_q);
      return r;
    end
    bg  = bg_model.exists(idx) ? longint'(bg_model[idx]) : 0;
    thr = thr_model.exists(idx) ? longint'(thr_model[idx]) : 0;
    // adapt only when the pixel moved against both earlier frames
    if (gap(cur, prev) > thr && gap(cur, older) > thr) begin
      bg = ((a * bg + (ONE_Q16 - a) * prev + LR_HALF) >> 16) & 64'hFFFF;
      nt = (a * thr + (ONE_Q16 - a) * THR_GAIN * gap(prev, bg) + LR_HALF) >> 16;
      if (nt > THR_MAX) nt = THR_MAX;
      bg_model[idx]  = 16'(bg);
      thr_model[idx] = 19'(nt);
      r.updated = 1'b1;
    end
    // floor division, so ties round upward
    num = FG_CUR_GAIN * cur - FG_BG_GAIN * bg + FG_ROUND;
    q = num / FG_DIV;
    if (num < 0 && q * FG_DIV != num) q = q - 1;
    if (q > FG_MAX) q = FG_MAX;
    if (q < FG_MIN) q = FG_MIN;
    r.fg_value = q;
    r.fg_bit   = (q > longint'(level_q));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count++;
    if (fail_count <= 40)
      $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    fg_result_t want;
    if (!rst_n) begin
      fg_expected.delete();
      learn_q         = LR_RESET;
      ithr_q          = ITHR_RESET;
      level_q         = LVL_RESET;
      fail_count      = 0;
      results_checked = 0;
      updates_seen    = 0;
      marked_seen     = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEARN_RATE: learn_q = cfg_data[LR_W-1:0];
          CFG_INIT_THR:   ithr_q  = cfg_data[ITHR_W-1:0];
          CFG_FG_LEVEL:   level_q = cfg_data[LVL_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        results_checked++;
        if (fg_expected.size() == 0) begin
          report_mismatch("result with nothing pending",
                          longint'(out_mon.foreground_value), 0);
        end else begin
          want = fg_expected.pop_front();
          if (out_mon.foreground_value !== 19'(want.fg_value))
            report_mismatch("foreground_value", longint'(out_mon.foreground_value),
                            want.fg_value);
          if (out_mon.foreground_bit !== want.fg_bit)
            report_mismatch("foreground_bit", longint'(out_mon.foreground_bit),
                            longint'(want.fg_bit));
          if (out_mon.model_updated !== want.updated)
            report_mismatch("model_updated", longint'(out_mon.model_updated),
                            longint'(want.updated));
          updates_seen += int'(want.updated);
          marked_seen  += int'(want.fg_bit);
        end
      end
      if (in_mon.valid && in_mon.ready)
        fg_expected.insert(fg_expected.size(),
            predict_foreground(in_mon.pixel_index, in_mon.current_pixel,
            in_mon.previous_pixel, in_mon.older_pixel, in_mon.init_pixel));
    end
    expected_left = fg_expected.size();
  end

endmodule

>>> sim/tb_adaptive_background_subtract.sv
module tb_adaptive_background_subtract;
  import abs_pkg::*;

  localparam int          POOL_SIZE     = 24;
  localparam int          HOLD_CYCLES   = 80;   // long output hold-off
  localparam int          SETTLE_CYCLES = 20;   // well past the pipeline latency
  localparam logic [15:0] SAMPLE_MAX    = 16'hFFFF;
  localparam pix_idx_t    LAST_PIXEL    = '1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  abs_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  abs_out_if #(.SAMPLE_BITS(16)) out_ch ();

  int fail_count;
  int expected_left;
  int results_checked;
  int updates_seen;
  int marked_seen;

  bit quiet = 1'b0;        // no idling on either side while set
  int holds_asked = 0;     // bumped by the pixel feed, served by the receiver
  int settings_used;

  // addresses that have been loaded by an init, safe to read back
  pix_idx_t pool [POOL_SIZE];
  int       walk_pos;

  always #5 clk = ~clk;

  adaptive_background_subtract #(
    .PIXEL_COUNT (131072),
    .SAMPLE_BITS (16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bg_model_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .expected_left   (expected_left),
    .results_checked (results_checked),
    .updates_seen    (updates_seen),
    .marked_seen     (marked_seen)
  );

  // hard stop, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("timeout with %0d results still pending", expected_left);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls, none while quiet, and long hold-offs on request
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 10);
      end
    end
  end

  // one pixel transfer, with random idle cycles ahead of it
  task automatic feed_pixel(input pix_idx_t idx, input logic [15:0] cur,
      input logic [15:0] prev, input logic [15:0] older, input logic init);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.pixel_index    <= idx;
    in_ch.current_pixel  <= cur;
    in_ch.previous_pixel <= prev;
    in_ch.older_pixel    <= older;
    in_ch.init_pixel     <= init;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // load background and threshold of one pixel
  task automatic load_pixel(input pix_idx_t idx, input logic [15:0] cur);
    feed_pixel(idx, cur, 16'h0, 16'h0, 1'b1);
  endtask

  // stop offering and wait until every result is back
  task automatic drain_pipe();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (expected_left == 0);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // registers only change with the pipeline empty
  task automatic apply_setting(input logic [15:0] lr, input logic [15:0] ithr,
      input logic [16:0] lvl);
    drain_pipe();
    write_reg(CFG_LEARN_RATE, CFG_DATA_W'(lr));
    write_reg(CFG_INIT_THR, CFG_DATA_W'(ithr));
    write_reg(CFG_FG_LEVEL, lvl);
    settings_used++;
  endtask

  // a sample close to v, so that some frame differences stay under threshold
  function automatic logic [15:0] near_sample(input logic [15:0] v);
    int d, s;
    d = $urandom_range(0, 1500);
    s = $urandom_range(1) ? int'(v) + d : int'(v) - d;
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return 16'(s);
  endfunction

  // one register setting: a fresh raster run of addresses, then mixed traffic
  task automatic run_phase(input logic [15:0] lr, input logic [15:0] ithr,
      input logic [16:0] lvl, input int n_items, input int quiet_items, input int hold_at);
    pix_idx_t    base, idx;
    logic [15:0] cur, prev, older;
    int          pick;
    apply_setting(lr, ithr, lvl);
    base = pix_idx_t'($urandom_range(0, 131071 - POOL_SIZE / 2));
    for (int k = 0; k < POOL_SIZE / 2; k++) begin
      pool[k] = base + pix_idx_t'(k);
      load_pixel(pool[k], 16'($urandom));
    end
    quiet = (quiet_items > 0);
    for (int n = 0; n < n_items; n++) begin
      if (n == quiet_items) quiet = 1'b0;
      if (n == hold_at) holds_asked++;
      // mostly walk the pool in raster order, otherwise jump around it
      if ($urandom_range(99) < 60) begin
        walk_pos = (walk_pos + 1) % POOL_SIZE;
        idx = pool[walk_pos];
      end else begin
        idx = pool[$urandom_range(POOL_SIZE - 1)];
      end
      if ($urandom_range(19) == 0)
        cur = $urandom_range(1) ? SAMPLE_MAX : 16'h0;
      else
        cur = 16'($urandom);
      prev  = $urandom_range(1) ? 16'($urandom) : near_sample(cur);
      older = $urandom_range(1) ? 16'($urandom) : near_sample(cur);
      pick = $urandom_range(99);
      if (pick < 3) begin
        // a brand-new address joins the carried-over half of the pool
        idx = pix_idx_t'($urandom);
        load_pixel(idx, cur);
        pool[$urandom_range(POOL_SIZE / 2, POOL_SIZE - 1)] = idx;
      end else if (pick < 9) begin
        load_pixel(idx, cur);
      end else begin
        feed_pixel(idx, cur, prev, older, 1'b0);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_LEARN_RATE;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.pixel_index    = '0;
    in_ch.current_pixel  = '0;
    in_ch.previous_pixel = '0;
    in_ch.older_pixel    = '0;
    in_ch.init_pixel     = 1'b0;
    walk_pos             = 0;
    settings_used        = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset register values: extreme addresses and samples
    load_pixel('0, 16'h0);
    load_pixel(LAST_PIXEL, SAMPLE_MAX);
    load_pixel(pix_idx_t'('h15555), 16'hAAAA);
    load_pixel(pix_idx_t'('h0AAAA), 16'h5555);
    feed_pixel('0, SAMPLE_MAX, 16'h0, 16'h0, 1'b0);           // adapt, top foreground
    feed_pixel(LAST_PIXEL, 16'h0, SAMPLE_MAX, SAMPLE_MAX, 1'b0); // adapt, negative
    feed_pixel(pix_idx_t'('h15555), 16'hAAAA, 16'hAAAA, 16'h0, 1'b0); // no motion vs prev
    feed_pixel(pix_idx_t'('h0AAAA), 16'h5555, 16'h0, 16'h5555, 1'b0); // no motion vs older
    // differences exactly at threshold, then one above
    load_pixel(pix_idx_t'(5), 16'd1000);
    feed_pixel(pix_idx_t'(5), 16'd1000, 16'd1655, 16'd345, 1'b0);
    feed_pixel(pix_idx_t'(5), 16'd1000, 16'd1656, 16'd344, 1'b0);
    // foreground just under the mask level, then just over it
    load_pixel(pix_idx_t'(7), 16'h0);
    feed_pixel(pix_idx_t'(7), 16'd23924, 16'd23924, 16'd23924, 1'b0);
    feed_pixel(pix_idx_t'(7), 16'd23925, 16'd23925, 16'd23925, 1'b0);
    feed_pixel('0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    feed_pixel(pix_idx_t'(5), 16'h0, SAMPLE_MAX, 16'h0, 1'b0);

    // low extremes: background jumps straight to prev, threshold collapses
    apply_setting(16'h0, 16'h0, 17'h0);
    load_pixel(pix_idx_t'(9), 16'd40000);
    feed_pixel(pix_idx_t'(9), 16'd40001, 16'd40000, 16'd39999, 1'b0);
    feed_pixel(pix_idx_t'(9), 16'h0, SAMPLE_MAX, SAMPLE_MAX, 1'b0);

    // high extremes: a loaded threshold can never be exceeded
    apply_setting(SAMPLE_MAX, SAMPLE_MAX, 17'h1FFFF);
    load_pixel(pix_idx_t'(11), SAMPLE_MAX);
    feed_pixel(pix_idx_t'(11), 16'h0, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    feed_pixel(LAST_PIXEL, SAMPLE_MAX, 16'h0, 16'h0, 1'b0);

    // carried-over half of the pool, extreme addresses included
    pool[POOL_SIZE / 2]     = '0;
    pool[POOL_SIZE / 2 + 1] = LAST_PIXEL;
    for (int k = POOL_SIZE / 2 + 2; k < POOL_SIZE; k++) pool[k] = pix_idx_t'($urandom);
    for (int k = POOL_SIZE / 2; k < POOL_SIZE; k++) load_pixel(pool[k], 16'($urandom));

    // random traffic across several settings, each change with the pipe drained
    run_phase(LR_RESET, ITHR_RESET, LVL_RESET, 260, 0, 100);
    run_phase(16'h0, 16'h0, 17'h0, 200, 150, -1);
    run_phase(SAMPLE_MAX, SAMPLE_MAX, 17'h1FFFF, 200, 0, -1);
    run_phase(16'($urandom), 16'($urandom_range(0, 4000)), 17'($urandom), 320, 0, -1);
    run_phase(16'h8000, 16'($urandom), 17'($urandom), 320, 0, 50);

    drain_pipe();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d pixel results under %0d register settings", results_checked,
             settings_used);
    $display("%0d results adapted the model, %0d were marked foreground", updates_seen,
             marked_seen);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
